### rtl/banked_interrupt_dispatcher_top_assert.svh
// assertion macros for the banked interrupt dispatcher
`ifndef BANKED_INTERRUPT_DISPATCHER_TOP_ASSERT_SVH
`define BANKED_INTERRUPT_DISPATCHER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define BID_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bid assertion failed");

// antecedent implies consequent in the next cycle
`define BID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bid assertion failed");

`endif

### rtl/bid_pkg.sv
// shared constants and types for the banked interrupt dispatcher
package bid_pkg;

	localparam int NUM_SOURCES = 72;
	localparam int BANK_WIDTH  = 32;
	localparam int WORD_W      = 32;
	localparam int IDX_W       = 7;
	localparam int POS_W       = 5;
	localparam int MEM_AW      = $clog2(NUM_SOURCES);
	localparam int HV_EXT_W    = 2 * BANK_WIDTH + WORD_W;

	localparam logic [WORD_W-1:0] BANK_MASK =
		(BANK_WIDTH >= WORD_W) ? '1 : WORD_W'((64'd1 << BANK_WIDTH) - 64'd1);
	localparam logic [IDX_W-1:0] BASE_BANK1 = IDX_W'(BANK_WIDTH);
	localparam logic [IDX_W-1:0] BASE_BANK2 = IDX_W'(2 * BANK_WIDTH);

	// operation codes
	localparam logic [1:0] OP_ENABLE   = 2'd0;
	localparam logic [1:0] OP_DISABLE  = 2'd1;
	localparam logic [1:0] OP_REGISTER = 2'd2;
	localparam logic [1:0] OP_SERVICE  = 2'd3;

	// bank codes
	localparam logic [1:0] BANK_0 = 2'd0;
	localparam logic [1:0] BANK_1 = 2'd1;
	localparam logic [1:0] BANK_2 = 2'd2;

	// status bit positions in the basic word
	localparam int GATE_BANK0_BIT = 8;
	localparam int GATE_BANK1_BIT = 9;

	typedef struct packed {
		logic update;      // apply enable, disable or register transaction
		logic load_mask;   // start a service run
		logic issue_read;  // pick highest source and read its context
		logic load_out;    // move picked result into the output register
	} bid_cmd_t;

	typedef struct packed {
		logic mask_empty;
		logic out_free;
	} bid_sts_t;

endpackage

### rtl/bid_ctrl.sv
// controller state machine for the banked interrupt dispatcher
module bid_ctrl import bid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] operation,
	input  bid_sts_t   sts,
	output logic       s_tready,
	output bid_cmd_t   cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

	state_t state_q;

	// command decode
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		cmd.update     = s_tready && s_tvalid && (operation != OP_SERVICE);
		cmd.load_mask  = s_tready && s_tvalid && (operation == OP_SERVICE);
		cmd.issue_read = (state_q == ST_SCAN) && !sts.mask_empty;
		cmd.load_out   = (state_q == ST_EMIT) && sts.out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_mask) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.mask_empty) state_q <= ST_IDLE;
					else state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						if (sts.mask_empty) state_q <= ST_IDLE;
						else state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/bid_datapath.sv
// enable and handler state, context memory, source picker and output register
module bid_datapath import bid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  bid_cmd_t          cmd,
	input  logic [1:0]        operation,
	input  logic [IDX_W-1:0]  irq_index,
	input  logic              handler_present,
	input  logic [WORD_W-1:0] context_tag,
	input  logic [1:0]        bank_select,
	input  logic [9:0]        basic_status,
	input  logic [WORD_W-1:0] pending_word,
	input  logic              m_tready,
	output bid_sts_t          sts,
	output logic              m_tvalid,
	output logic [IDX_W-1:0]  source_number,
	output logic [WORD_W-1:0] handler_context,
	output logic              last_in_run
);

	logic [WORD_W-1:0]      enable_q [3];
	logic [NUM_SOURCES-1:0] hv_q;
	logic [WORD_W-1:0]      ctx_mem [NUM_SOURCES];
	logic [WORD_W-1:0]      rdata_q;
	logic [WORD_W-1:0]      mask_q;
	logic [IDX_W-1:0]       base_q;
	logic [IDX_W-1:0]       src_q;
	logic                   last_q;
	logic                   m_tvalid_q;
	logic [IDX_W-1:0]       m_src_q;
	logic [WORD_W-1:0]      m_ctx_q;
	logic                   m_last_q;

	logic                   in_range;
	logic [1:0]             en_bank;
	logic [IDX_W-1:0]       en_pos;
	logic [HV_EXT_W-1:0]    hv_ext;
	logic [WORD_W-1:0]      svc_bits;
	logic [IDX_W-1:0]       svc_base;
	logic [POS_W-1:0]       pick_pos;
	logic [WORD_W-1:0]      pick_hot;
	logic [WORD_W-1:0]      mask_next;
	logic [IDX_W-1:0]       pick_src;

	// source decode for enable and disable
	always_comb begin
		in_range = (irq_index < IDX_W'(NUM_SOURCES));
		if (irq_index < BASE_BANK1) begin
			en_bank = BANK_0;
			en_pos  = irq_index;
		end else if (irq_index < BASE_BANK2) begin
			en_bank = BANK_1;
			en_pos  = irq_index - BASE_BANK1;
		end else begin
			en_bank = BANK_2;
			en_pos  = irq_index - BASE_BANK2;
		end
	end

	// enable words and handler valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q[0] <= '0;
			enable_q[1] <= '0;
			enable_q[2] <= '0;
			hv_q        <= '0;
		end else if (cmd.update && in_range) begin
			case (operation)
				OP_ENABLE: begin
					if (en_pos < IDX_W'(WORD_W))
						enable_q[en_bank][en_pos[POS_W-1:0]] <= 1'b1;
				end
				OP_DISABLE: begin
					if (en_pos < IDX_W'(WORD_W))
						enable_q[en_bank][en_pos[POS_W-1:0]] <= 1'b0;
				end
				OP_REGISTER: hv_q[irq_index[MEM_AW-1:0]] <= handler_present;
				default: ;
			endcase
		end
	end

	// context memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.update && in_range && (operation == OP_REGISTER))
			ctx_mem[irq_index[MEM_AW-1:0]] <= context_tag;
		if (cmd.issue_read)
			rdata_q <= ctx_mem[pick_src[MEM_AW-1:0]];
	end

	// handler bits windowed per bank, sources past the end read as absent
	assign hv_ext = HV_EXT_W'(hv_q);

	// candidates of the serviced bank
	always_comb begin
		svc_bits = '0;
		svc_base = '0;
		case (bank_select)
			BANK_0: begin
				if (basic_status[GATE_BANK0_BIT])
					svc_bits = pending_word & BANK_MASK & enable_q[0] & hv_ext[0 +: WORD_W];
			end
			BANK_1: begin
				svc_base = BASE_BANK1;
				if (basic_status[GATE_BANK1_BIT])
					svc_bits = pending_word & BANK_MASK & enable_q[1]
						& hv_ext[BANK_WIDTH +: WORD_W];
			end
			BANK_2: begin
				svc_base = BASE_BANK2;
				svc_bits = WORD_W'(basic_status[7:0]) & enable_q[2]
					& hv_ext[2*BANK_WIDTH +: WORD_W];
			end
			default: ;
		endcase
	end

	// highest set candidate
	always_comb begin
		pick_pos = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (mask_q[i]) pick_pos = POS_W'(i);
		end
		pick_hot  = WORD_W'(1) << pick_pos;
		mask_next = mask_q & ~pick_hot;
		pick_src  = base_q + IDX_W'(pick_pos);
	end

	// candidate mask and picked source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			base_q <= '0;
		end else if (cmd.load_mask) begin
			mask_q <= svc_bits;
			base_q <= svc_base;
		end else if (cmd.issue_read) begin
			mask_q <= mask_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue_read) begin
			src_q  <= pick_src;
			last_q <= (mask_next == '0);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_src_q  <= src_q;
			m_ctx_q  <= rdata_q;
			m_last_q <= last_q;
		end
	end

	assign sts.mask_empty = (mask_q == '0);
	assign sts.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid        = m_tvalid_q;
	assign source_number   = m_src_q;
	assign handler_context = m_ctx_q;
	assign last_in_run     = m_last_q;

endmodule

### rtl/banked_interrupt_dispatcher_top.sv
// top level of the banked interrupt dispatcher
//
// Input stream (s_*): one transaction per command. s_tuser carries the
// operation (enable, disable, register handler, service bank); s_tdata the
// source number, handler flag, context tag, bank, basic status and pending
// word. Enable, disable and register transactions take effect at acceptance
// and produce nothing. A service transaction produces one output transaction
// per enabled, pending source with a handler, highest source first, with
// tlast on the final one; none if nothing qualifies or a bank 0/1 gate is clear.
// Output stream (m_*): source number and stored context tag, tlast marks the
// end of a service run.
// Sequence: a service run loads the candidate mask at acceptance, then for
// each dispatched source picks it and reads its context memory, then loads
// the output register; when nothing qualifies it returns to idle after the
// first scan. The registered context memory read is why pick and output load
// are separate steps. Non-service commands leave the controller idle, so
// commands keep being accepted. s_tready is high only between service runs.
// Reset clears all enable bits and handler flags; context tags are unknown
// until registered. A stalled receiver holds the output register and pauses
// the run; the finished result waits while a new command can be accepted.
module banked_interrupt_dispatcher_top import bid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [6:0] irq_index, [7] handler_present, [39:8] context_tag,
	// [41:40] bank_select, [51:42] basic_status, [83:52] pending_word
	input  logic [87:0] s_tdata,
	// [1:0] operation
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [6:0] source_number, [38:7] handler_context
	output logic [39:0] m_tdata,
	output logic        m_tlast
);

	`include "banked_interrupt_dispatcher_top_assert.svh"

	bid_cmd_t          cmd;
	bid_sts_t          sts;
	logic [IDX_W-1:0]  source_number;
	logic [WORD_W-1:0] handler_context;

	// controller
	bid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.operation (s_tuser),
		.sts       (sts),
		.s_tready  (s_tready),
		.cmd       (cmd)
	);

	// datapath
	bid_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.operation       (s_tuser),
		.irq_index       (s_tdata[6:0]),
		.handler_present (s_tdata[7]),
		.context_tag     (s_tdata[39:8]),
		.bank_select     (s_tdata[41:40]),
		.basic_status    (s_tdata[51:42]),
		.pending_word    (s_tdata[83:52]),
		.m_tready        (m_tready),
		.sts             (sts),
		.m_tvalid        (m_tvalid),
		.source_number   (source_number),
		.handler_context (handler_context),
		.last_in_run     (m_tlast)
	);

	assign m_tdata = {1'b0, handler_context, source_number};

	// checks on controller and datapath cooperation
	`BID_ASSERT_IMPL(a_load_needs_room, cmd.load_out, sts.out_free)
	`BID_ASSERT_IMPL(a_pick_needs_candidate, cmd.issue_read, !sts.mask_empty)
	`BID_ASSERT_IMPL(a_idle_no_run, s_tready, !(cmd.issue_read || cmd.load_out))
	`BID_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, m_tvalid)

endmodule
